// ----- design/transient_resource_pool_assert.svh -----
// Assertion macros for the transient resource pool.
`ifndef TRANSIENT_RESOURCE_POOL_ASSERT_SVH
`define TRANSIENT_RESOURCE_POOL_ASSERT_SVH

// Checked only outside reset.
`define TRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define TRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/trp_pkg.sv -----
package trp_pkg;

  localparam int unsigned ENTRIES   = 32;
  localparam int unsigned KEY_WIDTH = 64;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned CMP_W     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int unsigned MEM_DEPTH = 2 * (2 ** IDX_W);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ACQUIRE = 2'd0;
  localparam kind_t KIND_RELEASE = 2'd1;
  localparam kind_t KIND_FRAME   = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_REUSED      = 3'd0;
  localparam status_t ST_CREATED     = 3'd1;
  localparam status_t ST_FULL        = 3'd2;
  localparam status_t ST_RELEASED    = 3'd3;
  localparam status_t ST_NOT_FOUND   = 3'd4;
  localparam status_t ST_FRAME_RESET = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } trp_state_e;

endpackage

// ----- design/transient_resource_pool.sv -----
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------------
// request  | in        | in_valid_i / in_stall_o | kind_i, pool_i, desc_key_i, slot_i
// result   | out       | out_valid_o/ out_stall_i| handle_slot_o, status_o
//
// Acquire walks the pool's key memory one entry per cycle, over its n entries,
// n being the pool's entry count (at most ENTRIES). Release and frame reset
// go straight from execute to done. One request is worked at a time. Reset
// clears marks and counts at once; key memory contents need no reset.
// A stalled result sits in the output register while the next request runs.
`include "transient_resource_pool_assert.svh"

module transient_resource_pool (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic                          pool_i,
  input  logic [63:0]                   desc_key_i,
  input  logic [trp_pkg::SLOT_W-1:0]    slot_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [trp_pkg::SLOT_W-1:0]    handle_slot_o,
  output logic [2:0]                    status_o
);
  import trp_pkg::*;

  trp_state_e state_q, state_d;

  kind_t                kind_q;
  logic                 pool_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [SLOT_W-1:0]    slot_q;

  logic [1:0][ENTRIES-1:0] mark_q, mark_d;
  logic [1:0][CNT_W-1:0]   cnt_q, cnt_d;

  logic [CNT_W-1:0] scan_q, scan_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q;

  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  status_t           res_st_q, res_st_d;

  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  status_t           out_st_q, out_st_d;

  logic [KEY_WIDTH-1:0] key_mem [MEM_DEPTH];
  logic [KEY_WIDTH-1:0] rdata_q;
  logic                 mem_re, mem_we;
  logic [IDX_W:0]       raddr, waddr;

  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] n_cur;
  logic             issue;
  logic             hit;
  logic             miss;
  logic             rel_ok;
  logic [IDX_W-1:0] rel_idx;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign n_cur    = cnt_q[pool_q];
  assign issue    = (state_q == S_SCAN) && (scan_q < n_cur);
  assign hit      = (state_q == S_SCAN) && rd_vld_q && !mark_q[pool_q][rd_idx_q]
                    && (rdata_q == key_q);
  assign miss     = (state_q == S_SCAN) && !rd_vld_q && !issue;
  assign rel_ok   = (CMP_W'(slot_q) < CMP_W'(n_cur)) && (CMP_W'(slot_q) < CMP_W'(ENTRIES));
  assign rel_idx  = IDX_W'(slot_q);

  assign raddr  = {pool_q, scan_q[IDX_W-1:0]};
  assign waddr  = {pool_q, n_cur[IDX_W-1:0]};
  assign mem_re = issue;
  assign mem_we = miss && (n_cur != CNT_W'(ENTRIES));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[waddr] <= key_q;
    end
    if (mem_re) begin
      rdata_q <= key_mem[raddr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: begin
        case (kind_q)
          KIND_ACQUIRE: state_d = S_SCAN;
          KIND_RELEASE,
          KIND_FRAME:   state_d = S_DONE;
          default:      state_d = S_IDLE;
        endcase
      end
      S_SCAN: if (hit || miss) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    mark_d      = mark_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    res_slot_d  = res_slot_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_st_d    = out_st_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_EXEC: begin
        scan_d     = '0;
        res_slot_d = '0;
        case (kind_q)
          KIND_RELEASE: begin
            if (rel_ok) begin
              mark_d[pool_q][rel_idx] = 1'b0;
              res_st_d = ST_RELEASED;
            end else begin
              res_st_d = ST_NOT_FOUND;
            end
          end
          KIND_FRAME: begin
            mark_d   = '0;
            res_st_d = ST_FRAME_RESET;
          end
          default: res_st_d = ST_FULL;
        endcase
      end
      S_SCAN: begin
        rd_vld_d = issue && !hit;
        if (issue) begin
          scan_d = scan_q + CNT_W'(1);
        end
        if (hit) begin
          mark_d[pool_q][rd_idx_q] = 1'b1;
          res_slot_d = SLOT_W'(rd_idx_q);
          res_st_d   = ST_REUSED;
        end else if (miss) begin
          if (n_cur == CNT_W'(ENTRIES)) begin
            res_slot_d = '0;
            res_st_d   = ST_FULL;
          end else begin
            mark_d[pool_q][n_cur[IDX_W-1:0]] = 1'b1;
            cnt_d[pool_q] = n_cur + CNT_W'(1);
            res_slot_d    = SLOT_W'(n_cur);
            res_st_d      = ST_CREATED;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = res_slot_q;
          out_st_d    = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mark_q      <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mark_q      <= mark_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      pool_q <= pool_i;
      key_q  <= desc_key_i[KEY_WIDTH-1:0];
      slot_q <= slot_i;
    end
    if (issue) begin
      rd_idx_q <= scan_q[IDX_W-1:0];
    end
    scan_q     <= scan_d;
    res_slot_q <= res_slot_d;
    res_st_q   <= res_st_d;
    out_slot_q <= out_slot_d;
    out_st_q   <= out_st_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign handle_slot_o = out_slot_q;
  assign status_o      = out_st_q;

  `TRP_ASSERT_ALWAYS(a_cnt_bound,
    (cnt_q[0] <= CNT_W'(ENTRIES)) && (cnt_q[1] <= CNT_W'(ENTRIES)),
    "pool count beyond capacity")
  `TRP_ASSERT(a_rd_in_scan, rd_vld_q |-> (state_q == S_SCAN),
    "key read data pending outside scan")
  `TRP_ASSERT(a_out_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE),
    "result raised without a finished item")
  `TRP_ASSERT(a_status_code, out_valid_o |-> (status_o <= ST_FRAME_RESET),
    "result status code out of range")

endmodule
